FILE: rtl/sha_pkg.sv
// Package with SHA-256 constants, types and round functions.
package sha_pkg;

	localparam int unsigned BufDepth = 64;
	localparam int unsigned BufAw = 6;
	localparam int unsigned WordW = 32;
	localparam logic [7:0] PadByte = 8'h80;

	typedef logic [WordW-1:0] word_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic byte_valid;
		logic last;
	} in_item_t;

	typedef struct packed {
		word_t digest_word;
		logic [2:0] word_index;
		logic final_word;
	} out_item_t;

	localparam word_t RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic word_t ror(input word_t x, input int unsigned n);
		return (x >> n) | (x << (WordW - n));
	endfunction

	function automatic word_t sig0(input word_t x);
		return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t sig1(input word_t x);
		return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t bsig0(input word_t x);
		return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
	endfunction

	function automatic word_t bsig1(input word_t x);
		return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
	endfunction

endpackage

FILE: rtl/sha_stream_if.sv
// Valid/ready stream interface carrying one payload.
interface sha_stream_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/sha_ram.sv
// Generic single-port RAM with registered read.
module sha_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

FILE: rtl/sha256_stream_hasher_top.sv
// Byte-stream SHA-256 hasher: byte buffer RAM, message schedule and round engine.
// An ordinary byte goes into the buffer as it is taken; the 64th byte of a block adds a
// compression (byte reads, 64 rounds, chain update) during which no input is taken;
// rounds run one per cycle; the buffer has one port. A last item adds padding (up to
// 72 buffer writes, one per cycle) and one or two compressions, then eight output
// transfers. Reset loads the initial hash and clears the fill count and bit length;
// the buffer RAM is not cleared.
module sha256_stream_hasher_top
	import sha_pkg::*;
(
	input logic clk,
	input logic arst_n,
	sha_stream_if.sink   in_ch,
	sha_stream_if.source out_ch
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_PAD, ST_LEN, ST_LOAD, ST_ROUND, ST_ADD, ST_EMIT
	} state_t;

	state_t state_q;
	logic [BufAw:0] fill_q;
	logic [63:0] bitlen_q;
	logic finish_q, second_q, mark_q;
	logic [6:0] cnt_q;
	word_t chain_q [8];
	word_t va_q, vb_q, vc_q, vd_q, ve_q, vf_q, vg_q, vh_q;
	word_t w_q [16];
	word_t wacc_q;
	logic rd_valid_s1;
	logic [1:0] rd_pos_s1;
	logic [2:0] out_idx_q;
	logic out_valid_q;

	logic ram_we;
	logic [BufAw-1:0] ram_addr;
	logic [7:0] ram_wdata, ram_rdata;

	in_item_t in_item;
	assign in_item = in_ch.data;

	sha_ram #(.Width(8), .Depth(BufDepth)) u_buf (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	logic in_fire;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_fire = in_ch.valid && in_ch.ready;

	// Round inputs: the first sixteen words come from the buffer, later ones from the window.
	word_t w_new, w_cur, t1, t2;
	always_comb begin
		w_new = sig1(w_q[14]) + w_q[9] + sig0(w_q[1]) + w_q[0];
		w_cur = (cnt_q < 7'd16) ? w_q[cnt_q[3:0]] : w_new;
		t1 = vh_q + bsig1(ve_q) + ((ve_q & vf_q) ^ (~ve_q & vg_q)) + RoundK[cnt_q[5:0]] + w_cur;
		t2 = bsig0(va_q) + ((va_q & vb_q) ^ (va_q & vc_q) ^ (vb_q & vc_q));
	end

	always_comb begin
		ram_we = 1'b0;
		ram_addr = fill_q[BufAw-1:0];
		ram_wdata = in_item.data_byte;
		case (state_q)
			ST_IDLE: begin
				ram_we = in_fire && in_item.byte_valid;
			end
			ST_PAD: begin
				ram_we = 1'b1;
				ram_wdata = mark_q ? PadByte : 8'h00;
			end
			ST_LEN: begin
				ram_we = 1'b1;
				ram_wdata = bitlen_q[8*(7-fill_q[2:0]) +: 8];
			end
			ST_LOAD: begin
				ram_addr = cnt_q[BufAw-1:0];
			end
			default: ;
		endcase
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data = '{digest_word: chain_q[out_idx_q], word_index: out_idx_q,
		final_word: (out_idx_q == 3'd7)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			bitlen_q <= '0;
			finish_q <= 1'b0;
			second_q <= 1'b0;
			mark_q <= 1'b0;
			cnt_q <= '0;
			chain_q <= InitHash;
			rd_valid_s1 <= 1'b0;
			out_idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						finish_q <= in_item.last;
						mark_q <= in_item.last;
						cnt_q <= '0;
						if (in_item.byte_valid) begin
							bitlen_q <= bitlen_q + 64'd8;
							fill_q <= fill_q + 1'b1;
							if (fill_q == 7'd63) begin
								// A last byte that fills the block leaves the padding
								// for a block of its own.
								fill_q <= '0;
								second_q <= in_item.last;
								state_q <= ST_LOAD;
							end else if (in_item.last) begin
								state_q <= ST_PAD;
							end
						end else if (in_item.last) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					// The 0x80 marker if not yet written, then zeros up to the length field, or to the block end.
					cnt_q <= 7'd1;
					mark_q <= 1'b0;
					fill_q <= fill_q + 1'b1;
					if (fill_q == 7'd63) begin
						fill_q <= '0;
						second_q <= 1'b1;
						cnt_q <= '0;
						state_q <= ST_LOAD;
					end else if (fill_q == 7'd55) begin
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					fill_q <= fill_q + 1'b1;
					if (fill_q == 7'd63) begin
						fill_q <= '0;
						second_q <= 1'b0;
						finish_q <= 1'b1;
						cnt_q <= '0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					// Bytes arrive in the cycle after their address; four make a word.
					if (cnt_q < 7'd64) begin
						cnt_q <= cnt_q + 1'b1;
					end
					rd_valid_s1 <= (cnt_q < 7'd64);
					rd_pos_s1 <= cnt_q[1:0];
					if (rd_valid_s1) begin
						wacc_q <= {wacc_q[23:0], ram_rdata};
						if (rd_pos_s1 == 2'd3) begin
							w_q[cnt_q[5:2] - 4'd1] <= {wacc_q[23:0], ram_rdata};
						end
					end
					if (cnt_q == 7'd64 && !rd_valid_s1) begin
						va_q <= chain_q[0]; vb_q <= chain_q[1];
						vc_q <= chain_q[2]; vd_q <= chain_q[3];
						ve_q <= chain_q[4]; vf_q <= chain_q[5];
						vg_q <= chain_q[6]; vh_q <= chain_q[7];
						cnt_q <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					if (cnt_q >= 7'd16) begin
						for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
						w_q[15] <= w_new;
					end
					vh_q <= vg_q; vg_q <= vf_q; vf_q <= ve_q; ve_q <= vd_q + t1;
					vd_q <= vc_q; vc_q <= vb_q; vb_q <= va_q; va_q <= t1 + t2;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 7'd63) begin
						cnt_q <= '0;
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					// One chain word per cycle, rotating the working registers.
					chain_q[cnt_q[2:0]] <= chain_q[cnt_q[2:0]] + va_q;
					va_q <= vb_q; vb_q <= vc_q; vc_q <= vd_q; vd_q <= ve_q;
					ve_q <= vf_q; vf_q <= vg_q; vg_q <= vh_q;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 7'd7) begin
						cnt_q <= '0;
						if (second_q) begin
							state_q <= ST_PAD;
						end else if (finish_q) begin
							out_idx_q <= '0;
							out_valid_q <= 1'b1;
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_EMIT: begin
					if (out_ch.ready) begin
						out_idx_q <= out_idx_q + 1'b1;
						if (out_idx_q == 3'd7) begin
							out_valid_q <= 1'b0;
							chain_q <= InitHash;
							bitlen_q <= '0;
							fill_q <= '0;
							finish_q <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The round counter never passes the last round.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND |-> cnt_q < 7'd64)
		else $error("round counter overrun");

	// Results appear only while emitting the digest.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> state_q == ST_EMIT)
		else $error("result outside emit phase");

	// The buffer is never written during a compression.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND || state_q == ST_LOAD || state_q == ST_ADD) |-> !ram_we)
		else $error("buffer written during compression");

	// Padding leaves the length field for the last eight bytes.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LEN |-> fill_q >= 7'd56)
		else $error("length written too early");
endmodule
